### hdl/est_pkg.sv
package est_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int COUNT_W             = 11;
    localparam int INDEX_W             = 10;
    localparam int VALUE_W             = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] entry_value;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } rsp_word_t;

endpackage

### hdl/est_ram.sv
module est_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/exponential_search_table_unit.sv
// Write word: accepted while idle, no result; the next word may follow at once.
// Search word: one table read per cycle through the single read port, g galloping
// reads plus s binary-search reads; no new word is taken until the result has
// been registered for output, and a stalled output holds the unit in ST_FIN.
// Reset clears the control state, out_valid and the element count (count_reg); table
// contents are undefined until written, and there is no clearing pass.
module exponential_search_table_unit #(
    parameter int TABLE_DEPTH = est_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  est_pkg::req_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output est_pkg::rsp_word_t            out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [est_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = (AW + 1 > est_pkg::COUNT_W) ? AW + 1 : est_pkg::COUNT_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_GALLOP  = 3'd1;
    localparam logic [2:0] ST_BSTART  = 3'd2;
    localparam logic [2:0] ST_BSEARCH = 3'd3;
    localparam logic [2:0] ST_FIN     = 3'd4;

    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    logic [2:0]                           state_reg, state_next;
    logic [est_pkg::COUNT_W-1:0]          count_reg;
    logic [NW-1:0]                        n_reg, n_next;
    logic [NW-1:0]                        b_reg, b_next;
    logic [NW-1:0]                        lo_reg, lo_next;
    logic [NW-1:0]                        hi_reg, hi_next;
    logic [NW-1:0]                        mid_reg, mid_next;
    logic signed [est_pkg::VALUE_W-1:0]   key_reg, key_next;
    logic                                 res_found_reg, res_found_next;
    logic [est_pkg::INDEX_W-1:0]          res_index_reg, res_index_next;
    logic                                 out_valid_reg, out_valid_next;
    est_pkg::rsp_word_t                   out_word_reg, out_word_next;

    logic                                 accept;
    logic [NW-1:0]                        n_sat;
    logic [NW-1:0]                        idx_ext;
    logic                                 wr_en;
    logic [NW-1:0]                        rd_sel;
    logic signed [est_pkg::VALUE_W-1:0]   rd_data;
    logic [NW-1:0]                        b_dbl;
    logic [NW-1:0]                        lo_c, hi_c, mid_c;
    logic [NW-1:0]                        mid_left, mid_right;
    logic                                 out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign n_sat    = (NW'(count_reg) > DEPTH_N) ? DEPTH_N : NW'(count_reg);
    assign idx_ext  = NW'(in_word.entry_index);
    assign wr_en    = accept && (in_word.req_type == est_pkg::REQ_WRITE) && (idx_ext < DEPTH_N);
    assign b_dbl    = b_reg << 1;
    assign lo_c     = b_reg >> 1;
    assign hi_c     = (b_reg < n_reg - ONE_N) ? b_reg : n_reg - ONE_N;
    assign mid_c    = lo_c + ((hi_c - lo_c) >> 1);
    assign mid_left  = lo_reg + ((mid_reg - ONE_N - lo_reg) >> 1);
    assign mid_right = mid_reg + ONE_N + ((hi_reg - mid_reg - ONE_N) >> 1);
    assign out_free  = !out_valid_reg || !out_stall;

    est_ram #(
        .WIDTH (est_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_ext[AW-1:0]),
        .wdata (in_word.entry_value),
        .raddr (rd_sel[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        b_next         = b_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        rd_sel         = ONE_N;

        case (state_reg)
            ST_IDLE:
            begin
                rd_sel = ONE_N;
                if (accept && (in_word.req_type == est_pkg::REQ_SEARCH))
                begin
                    key_next       = in_word.entry_value;
                    n_next         = n_sat;
                    b_next         = ONE_N;
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    if (n_sat == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (ONE_N < n_sat)
                    begin
                        state_next = ST_GALLOP;
                    end
                    else
                    begin
                        state_next = ST_BSTART;
                    end
                end
            end
            ST_GALLOP:
            begin
                rd_sel = b_dbl;
                if (rd_data < key_reg)
                begin
                    b_next = b_dbl;
                    if (b_dbl >= n_reg)
                    begin
                        state_next = ST_BSTART;
                    end
                end
                else
                begin
                    state_next = ST_BSTART;
                end
            end
            ST_BSTART:
            begin
                rd_sel     = mid_c;
                lo_next    = lo_c;
                hi_next    = hi_c;
                mid_next   = mid_c;
                state_next = ST_BSEARCH;
            end
            ST_BSEARCH:
            begin
                if (rd_data == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_index_next = mid_reg[est_pkg::INDEX_W-1:0];
                    state_next     = ST_FIN;
                end
                else if (rd_data > key_reg)
                begin
                    rd_sel   = mid_left;
                    hi_next  = mid_reg - ONE_N;
                    mid_next = mid_left;
                    if (mid_reg <= lo_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    rd_sel   = mid_right;
                    lo_next  = mid_reg + ONE_N;
                    mid_next = mid_right;
                    if (mid_reg >= hi_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.found       = res_found_reg;
                    out_word_next.found_index = res_index_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        b_reg         <= b_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        out_word_reg  <= out_word_next;
    end

endmodule

### hdl/est_checker.sv
module est_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  est_pkg::req_word_t in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  est_pkg::rsp_word_t out_word
);

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.found |-> out_word.found_index == '0)
        else $error("miss carries a non-zero index");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.req_type == est_pkg::REQ_WRITE |=> !in_stall)
        else $error("write word left the unit busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.req_type == est_pkg::REQ_SEARCH |=> in_stall)
        else $error("search word did not occupy the unit");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search in progress");

endmodule

bind exponential_search_table_unit est_checker u_est_checker (.*);

### verif/est_result_checker.sv
module est_result_checker
    import est_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  req_word_t in_word,
    input  logic      out_valid,
    input  logic      out_stall,
    input  rsp_word_t out_word,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output int        failures,
    output int        pending,
    output int        searches,
    output int        hits
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [VALUE_W-1:0] entries [DEPTH];
    logic [COUNT_W-1:0]        span;
    rsp_word_t                 due_results [$];

    function automatic rsp_word_t gallop_search(input logic signed [VALUE_W-1:0] key);
        rsp_word_t r;
        int n;
        int b;
        int lo;
        int hi;
        int mid;
        r = '0;
        n = (int'(span) > DEPTH) ? DEPTH : int'(span);
        if (n == 0)
            return r;
        b = 1;
        while (b < n && entries[b] < key)
            b = b * 2;
        lo = b / 2;
        hi = (b < n - 1) ? b : n - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] == key)
            begin
                r.found       = 1'b1;
                r.found_index = mid[INDEX_W-1:0];
                return r;
            end
            if (entries[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    task automatic note_failure(input string why, input rsp_word_t want, input rsp_word_t got);
        failures++;
        if (failures <= 10)
            $display("%s: expected found=%0b index=%0d, got found=%0b index=%0d",
                     why, want.found, want.found_index, got.found, got.found_index);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_word_t want;
        if (!rst_n)
        begin
            span = '0;
            due_results.delete();
            failures = 0;
            pending  = 0;
            searches = 0;
            hits     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                span = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (in_word.req_type == REQ_SEARCH)
                    due_results.push_back(gallop_search(in_word.entry_value));
                else if (int'(in_word.entry_index) < DEPTH)
                    entries[in_word.entry_index] = in_word.entry_value;
            end
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    note_failure("result with none due", '0, out_word);
                else
                begin
                    want = due_results.pop_front();
                    searches++;
                    if (want.found)
                        hits++;
                    if (out_word.found !== want.found
                        || out_word.found_index !== want.found_index)
                        note_failure("search result mismatch", want, out_word);
                end
            end
            pending = due_results.size();
        end
    end

endmodule

### verif/tb_exponential_search_table_unit.sv
module tb_exponential_search_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import est_pkg::*;

    localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
    localparam int SETTLE         = 40;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int LIMIT          = 1_000_000;
    localparam int ITEM_TARGET    = 1100;

    localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    req_word_t          in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rsp_word_t          out_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;

    int failures;
    int pending;
    int searches;
    int hits;
    int cycles      = 0;
    int items_sent  = 0;
    int writes_sent = 0;
    int spans_set   = 0;
    int span_now    = 0;
    bit tx_calm         = 1'b1;
    bit rx_calm         = 1'b1;
    bit squeeze_pending = 1'b0;

    logic signed [VALUE_W-1:0] shadow [DEPTH];

    exponential_search_table_unit #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    est_result_checker #(
        .DEPTH (DEPTH)
    ) result_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending),
        .searches  (searches),
        .hits      (hits)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("[exponential_search_table_unit] ERROR");
            $finish;
        end
    end

    task automatic send_req(input req_word_t w);
        int r;
        int g;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        g = 0;
        if (!tx_calm)
        begin
            r = $urandom_range(0, 99);
            if (r >= 93)
                g = $urandom_range(8, 30);
            else if (r >= 70)
                g = $urandom_range(1, 3);
        end
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic put_entry(input int idx, input logic signed [VALUE_W-1:0] v);
        req_word_t w;
        w.req_type    = REQ_WRITE;
        w.entry_index = idx[INDEX_W-1:0];
        w.entry_value = v;
        shadow[idx]   = v;
        send_req(w);
        writes_sent++;
    endtask

    task automatic find_key(input logic signed [VALUE_W-1:0] key);
        req_word_t w;
        w.req_type    = REQ_SEARCH;
        w.entry_index = INDEX_W'($urandom);
        w.entry_value = key;
        send_req(w);
    endtask

    // drain everything due, then let any write in flight retire
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_span(input int n);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= n[COUNT_W-1:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        span_now = n;
        spans_set++;
    endtask

    // ascending fill of entries 0..n-1, wide or dense steps, now and then random order
    task automatic load_table(input int n, input bit noisy);
        longint v;
        longint stepmax;
        int mode;
        logic signed [VALUE_W-1:0] val;
        mode = $urandom_range(0, 9);
        if (mode == 9 && !noisy)
            mode = 8;
        if (mode < 5)
        begin
            v       = longint'(KEY_MIN) + $urandom_range(0, 2);
            stepmax = 64'hFFFF_FFFF / n;
        end
        else
        begin
            v       = longint'($signed($urandom)) / 2;
            stepmax = 3;
        end
        for (int i = 0; i < n; i++)
        begin
            val = (mode == 9) ? $urandom : v[31:0];
            if (mode == 4 && i == n - 1)
                val = KEY_MAX;
            put_entry(i, val);
            v += $urandom_range(0, 32'(stepmax));
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_key(input int n);
        int r;
        int i;
        r = $urandom_range(0, 99);
        i = $urandom_range(0, n - 1);
        if (r < 60)
            return shadow[i];
        if (r < 75)
            return shadow[i] + (r[0] ? 1 : -1);
        if (r < 80)
            return KEY_MIN;
        if (r < 85)
            return KEY_MAX;
        return $urandom;
    endfunction

    // searches over the loaded prefix, with stray writes above it
    task automatic search_burst(input int count);
        int n;
        for (int k = 0; k < count; k++)
        begin
            n = (span_now > DEPTH) ? DEPTH : span_now;
            if ($urandom_range(0, 99) < 8 && n < DEPTH)
                put_entry($urandom_range(n, DEPTH - 1), $urandom);
            else if (n == 0)
                find_key($urandom);
            else
                find_key(pick_key(n));
        end
    endtask

    initial
    begin : drain
        int len;
        forever
        begin
            @(posedge clk);
            if (squeeze_pending)
            begin
                squeeze_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else if (rx_calm || $urandom_range(0, 3) != 0)
                out_stall <= 1'b0;
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int phase;
        int big_spans [6];
        big_spans = '{2047, 1024, 1025, 1023, 700, 513};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        set_span(0);
        find_key(KEY_MIN);
        find_key(KEY_MAX);
        put_entry(0, KEY_MIN);
        put_entry(1, -1000);
        put_entry(2, -1);
        put_entry(3, 0);
        put_entry(4, 0);
        put_entry(5, 5);
        put_entry(6, 77);
        put_entry(7, KEY_MAX);
        set_span(8);
        find_key(KEY_MIN);
        find_key(KEY_MAX);
        find_key(-1);
        find_key(6);
        find_key(77);
        find_key(0);
        set_span(1);
        find_key(KEY_MIN);
        find_key(0);
        // break the ordering
        put_entry(2, KEY_MAX);
        set_span(8);
        find_key(-1);
        find_key(77);

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        load_table(DEPTH, 1'b0);
        foreach (big_spans[k])
        begin
            set_span(big_spans[k]);
            search_burst(10);
        end

        phase = 0;
        while (items_sent < ITEM_TARGET || phase < 3)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 40);
            load_table(n, 1'b1);
            set_span(($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n);
            if (phase == 2)
            begin
                // hold the output off while words keep coming
                tx_calm         = 1'b1;
                rx_calm         = 1'b1;
                squeeze_pending = 1'b1;
            end
            search_burst($urandom_range(15, 40));
            phase++;
        end
        settle();

        $display("%0d words sent: %0d table writes, %0d searches checked (%0d hits)",
                 items_sent, writes_sent, searches, hits);
        $display("%0d count settings, from empty through full and saturated, sorted and unsorted",
                 spans_set);
        if (failures == 0)
            $display("[exponential_search_table_unit] OK");
        else
            $display("[exponential_search_table_unit] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/est_pkg.sv
hdl/est_ram.sv
hdl/exponential_search_table_unit.sv
hdl/est_checker.sv
verif/est_result_checker.sv
verif/tb_exponential_search_table_unit.sv
